>>> rtl/csv_field_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL.
// Expects a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

// same-cycle implication
`define CSVT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csvt assertion failed");

// next-cycle implication
`define CSVT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csvt assertion failed");

`endif

>>> rtl/csvt_pkg.sv
// Shared types and codes for the CSV field tokenizer.
// No dependencies.
`default_nettype none
package csvt_pkg;

    // scanner states
    localparam logic [1:0] SC_AFTER  = 2'd0;
    localparam logic [1:0] SC_FIELD  = 2'd1;
    localparam logic [1:0] SC_QUOTED = 2'd2;
    localparam logic [1:0] SC_QSEEN  = 2'd3;

    // token codes passed from front to back
    localparam logic [2:0] TK_BYTE       = 3'd0;
    localparam logic [2:0] TK_FIELD      = 3'd1;
    localparam logic [2:0] TK_LINE       = 3'd2;
    localparam logic [2:0] TK_FIELD_LINE = 3'd3;
    localparam logic [2:0] TK_STATUS     = 3'd4;

    // status values
    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_QUOTE_SEP  = 3'd1;
    localparam logic [2:0] STS_CHAR_SEP   = 3'd2;
    localparam logic [2:0] STS_UNTERM     = 3'd3;
    localparam logic [2:0] STS_NO_LINE    = 3'd4;

    // characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [7:0] SEP_RESET = CH_COMMA;

    // data holds the byte for TK_BYTE and the status for TK_STATUS
    typedef struct packed {
        logic [2:0] code;
        logic [7:0] data;
    } t_token;

endpackage
`default_nettype wire

>>> rtl/csvt_front.sv
// Front end: separator register, scanner state and per-byte classification.
// Uses csvt_pkg; emits at most one token per accepted item into the token queue.
`default_nettype none
module csvt_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    input  wire logic [7:0]      i_cfg_data,
    input  wire logic            i_accept,
    input  wire logic            i_kind,
    input  wire logic [7:0]      i_in_byte,
    output csvt_pkg::t_token     o_token,
    output logic                 o_emit
);
    import csvt_pkg::*;
`include "csv_field_tokenizer_defines.svh"

    logic [7:0] r_sep;
    logic [1:0] r_state, n_state;
    logic       r_has, n_has;
    t_token     tok;
    logic       emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
        end else if (i_cfg_valid) begin
            r_sep <= i_cfg_data;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_has     = r_has;
        emit      = 1'b0;
        tok.code  = TK_BYTE;
        tok.data  = i_in_byte;
        if (i_kind) begin
            emit = 1'b1;
            if (!r_has) begin
                tok.code = TK_STATUS;
                tok.data = {5'd0, STS_NO_LINE};
            end else if (r_state == SC_AFTER) begin
                tok.code = TK_LINE;
            end else if (r_state == SC_QUOTED) begin
                tok.code = TK_STATUS;
                tok.data = {5'd0, STS_UNTERM};
            end else begin
                tok.code = TK_FIELD_LINE;
            end
        end else if (i_in_byte == CH_CR) begin
            unique case (r_state)
                SC_QUOTED: emit = 1'b1;
                SC_QSEEN: begin
                    emit     = 1'b1;
                    tok.code = TK_FIELD;
                    n_state  = SC_AFTER;
                end
                default: emit = 1'b0;
            endcase
        end else if (i_in_byte == CH_LF) begin
            emit = 1'b1;
            unique case (r_state)
                SC_AFTER:  tok.code = TK_LINE;
                SC_FIELD:  tok.code = r_has ? TK_FIELD_LINE : TK_LINE;
                SC_QUOTED: n_has = 1'b1;
                default:   tok.code = TK_FIELD_LINE;
            endcase
        end else begin
            n_has = 1'b1;
            if (i_in_byte == CH_QUOTE) begin
                unique case (r_state)
                    SC_AFTER: begin
                        emit     = 1'b1;
                        tok.code = TK_STATUS;
                        tok.data = {5'd0, STS_QUOTE_SEP};
                    end
                    SC_FIELD:  n_state = SC_QUOTED;
                    SC_QUOTED: n_state = SC_QSEEN;
                    default: begin
                        // doubled quote gives one quote
                        emit    = 1'b1;
                        n_state = SC_QUOTED;
                    end
                endcase
            end else if (i_in_byte == r_sep && !(i_in_byte == CH_SPACE && r_state == SC_QSEEN)) begin
                // separator handling, space separator included
                unique case (r_state)
                    SC_AFTER: n_state = SC_FIELD;
                    SC_FIELD: begin
                        emit     = 1'b1;
                        tok.code = TK_FIELD;
                    end
                    SC_QUOTED: emit = 1'b1;
                    default: begin
                        emit     = 1'b1;
                        tok.code = TK_FIELD;
                        n_state  = SC_FIELD;
                    end
                endcase
            end else if (i_in_byte == CH_SPACE) begin
                emit = 1'b1;
                if (r_state == SC_QSEEN) begin
                    tok.code = TK_FIELD;
                    n_state  = (r_sep == CH_SPACE) ? SC_FIELD : SC_AFTER;
                end
            end else begin
                emit = 1'b1;
                unique case (r_state)
                    SC_AFTER: begin
                        tok.code = TK_STATUS;
                        tok.data = {5'd0, STS_CHAR_SEP};
                    end
                    SC_FIELD, SC_QUOTED: tok.code = TK_BYTE;
                    default: begin
                        // byte after closing quote is dropped
                        tok.code = TK_FIELD;
                        n_state  = SC_AFTER;
                    end
                endcase
            end
        end
        // line end or error restarts the line
        if (emit && (tok.code == TK_LINE || tok.code == TK_FIELD_LINE ||
                     tok.code == TK_STATUS)) begin
            n_state = SC_FIELD;
            n_has   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_FIELD;
            r_has   <= 1'b0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_has   <= n_has;
        end
    end

    assign o_token = tok;
    assign o_emit  = emit;

    `CSVT_ASSERT_NXT(a_line_restart, i_accept && emit && (tok.code == TK_LINE || tok.code == TK_STATUS), r_state == SC_FIELD && !r_has)
    `CSVT_ASSERT_NXT(a_hold_idle, !i_accept, $stable(r_state) && $stable(r_has))
    `CSVT_ASSERT_IMP(a_status_range, emit && tok.code == TK_STATUS, tok.data[2:0] != STS_OK && tok.data[7:3] == 5'd0)

endmodule
`default_nettype wire

>>> rtl/csvt_queue.sv
// Token queue between front and back ends.
// Uses csvt_pkg for the token type.
`default_nettype none
module csvt_queue #(
    parameter int QDEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr,
    input  csvt_pkg::t_token i_token,
    output logic             o_full,
    input  wire logic        i_rd,
    output logic             o_empty,
    output csvt_pkg::t_token o_token
);
    import csvt_pkg::*;
`include "csv_field_tokenizer_defines.svh"

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QDEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QDEPTH);

    t_token        r_mem [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;
    logic          wr_en, rd_en;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_token = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            if (rd_en) r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            if (wr_en && !rd_en) r_count <= r_count + 1'b1;
            else if (rd_en && !wr_en) r_count <= r_count - 1'b1;
        end
    end

    `CSVT_ASSERT_IMP(a_no_overflow, o_full, !wr_en)
    `CSVT_ASSERT_NXT(a_count_up, wr_en && !rd_en, r_count == $past(r_count) + CW'(1))
    `CSVT_ASSERT_IMP(a_ptr_match, o_empty || o_full, r_wp == r_rp)

endmodule
`default_nettype wire

>>> rtl/csvt_back.sv
// Back end: output register that decodes tokens into result fields.
// Uses csvt_pkg; reads the token queue and presents results with empty/pop.
`default_nettype none
module csvt_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_empty,
    input  csvt_pkg::t_token i_token,
    output logic             o_q_rd,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic             o_byte_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_field_end,
    output logic             o_line_end,
    output logic [2:0]       o_status
);
    import csvt_pkg::*;

    logic       r_valid;
    logic       r_bv, r_fe, r_le;
    logic [7:0] r_byte;
    logic [2:0] r_sts;
    logic       load;

    assign load   = !i_q_empty && (!r_valid || i_pop);
    assign o_q_rd = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bv   <= (i_token.code == TK_BYTE);
            r_byte <= (i_token.code == TK_BYTE) ? i_token.data : 8'd0;
            r_fe   <= (i_token.code == TK_FIELD) || (i_token.code == TK_FIELD_LINE);
            r_le   <= (i_token.code == TK_LINE) || (i_token.code == TK_FIELD_LINE);
            r_sts  <= (i_token.code == TK_STATUS) ? i_token.data[2:0] : STS_OK;
        end
    end

    assign o_empty      = !r_valid;
    assign o_byte_valid = r_bv;
    assign o_out_byte   = r_byte;
    assign o_field_end  = r_fe;
    assign o_line_end   = r_le;
    assign o_status     = r_sts;

endmodule
`default_nettype wire

>>> rtl/csv_field_tokenizer.sv
// Top level of the CSV field tokenizer.
// Instantiates csvt_front, csvt_queue and csvt_back; uses csvt_pkg.
`default_nettype none
// One byte or end-of-input marker is taken per cycle while full is low; each
// causes at most one result. A result passes through the token queue and then
// into the output register when that register is free. The front end updates the
// scanner in the same cycle the item arrives, so items can be pushed every
// cycle; full rises only when the QDEPTH-entry token queue and the output
// register are both occupied because results are not being popped. The
// separator write port is always ready and must only be written while the
// block is idle.
module csv_field_tokenizer #(
    parameter int QDEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       push,
    output logic            full,
    input  wire logic       i_kind,
    input  wire logic [7:0] i_in_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic            o_byte_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_field_end,
    output logic            o_line_end,
    output logic [2:0]      o_status
);
    import csvt_pkg::*;

    t_token tok_in, tok_out;
    logic   emit, accept, q_full, q_empty, q_rd;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    csvt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_kind      (i_kind),
        .i_in_byte   (i_in_byte),
        .o_token     (tok_in),
        .o_emit      (emit)
    );

    csvt_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept && emit),
        .i_token (tok_in),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_token (tok_out)
    );

    csvt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_token      (tok_out),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_byte_valid (o_byte_valid),
        .o_out_byte   (o_out_byte),
        .o_field_end  (o_field_end),
        .o_line_end   (o_line_end),
        .o_status     (o_status)
    );

endmodule
`default_nettype wire

>>> tb/csvt_token_checker.sv
// Scoreboard for the CSV field tokenizer: watches the separator write port and both queue sides.
// Predicts each result from a local copy of the scanner. Uses csvt_pkg.
`default_nettype none
module csvt_token_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    input  wire logic       i_cfg_ready,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_push,
    input  wire logic       i_full,
    input  wire logic       i_kind,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_empty,
    input  wire logic       i_pop,
    input  wire logic       i_byte_valid,
    input  wire logic [7:0] i_out_byte,
    input  wire logic       i_field_end,
    input  wire logic       i_line_end,
    input  wire logic [2:0] i_status,
    output int              o_errors,
    output int              o_pending
);
    import csvt_pkg::*;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       field_end;
        logic       line_end;
        logic [2:0] status;
    } t_csv_result;

    t_csv_result expected_tokens[$];

    logic [7:0] sep_byte   = SEP_RESET;
    logic [1:0] scan_st    = SC_FIELD;
    logic       line_chars = 1'b0;
    int         errors     = 0;

    // Advance the local scanner by one item; emit is set when a result is produced.
    task automatic tokenize_item(input logic kind, input logic [7:0] b,
                                 output logic emit, output t_csv_result res);
        res  = '0;
        emit = 1'b1;
        if (kind) begin
            if (!line_chars)
                res.status = STS_NO_LINE;
            else if (scan_st == SC_AFTER)
                res.line_end = 1'b1;
            else if (scan_st == SC_QUOTED)
                res.status = STS_UNTERM;
            else begin
                res.field_end = 1'b1;
                res.line_end  = 1'b1;
            end
        end else if (b == CH_CR) begin
            if (scan_st == SC_QUOTED) begin
                res.byte_valid = 1'b1;
                res.out_byte   = b;
            end else if (scan_st == SC_QSEEN) begin
                scan_st       = SC_AFTER;
                res.field_end = 1'b1;
            end else
                emit = 1'b0;
        end else if (b == CH_LF) begin
            case (scan_st)
                SC_AFTER:  res.line_end = 1'b1;
                SC_FIELD: begin
                    res.field_end = line_chars;
                    res.line_end  = 1'b1;
                end
                SC_QUOTED: begin
                    line_chars     = 1'b1;
                    res.byte_valid = 1'b1;
                    res.out_byte   = b;
                end
                default: begin
                    res.field_end = 1'b1;
                    res.line_end  = 1'b1;
                end
            endcase
        end else begin
            line_chars = 1'b1;
            if (b == CH_QUOTE) begin
                case (scan_st)
                    SC_AFTER:  res.status = STS_QUOTE_SEP;
                    SC_FIELD: begin
                        scan_st = SC_QUOTED;
                        emit    = 1'b0;
                    end
                    SC_QUOTED: begin
                        scan_st = SC_QSEEN;
                        emit    = 1'b0;
                    end
                    default: begin
                        // doubled quote inside a quoted field
                        scan_st        = SC_QUOTED;
                        res.byte_valid = 1'b1;
                        res.out_byte   = b;
                    end
                endcase
            end else if (b == CH_SPACE && scan_st == SC_QSEEN) begin
                scan_st       = (sep_byte == CH_SPACE) ? SC_FIELD : SC_AFTER;
                res.field_end = 1'b1;
            end else if (b == sep_byte) begin
                case (scan_st)
                    SC_AFTER: begin
                        scan_st = SC_FIELD;
                        emit    = 1'b0;
                    end
                    SC_FIELD:  res.field_end = 1'b1;
                    SC_QUOTED: begin
                        res.byte_valid = 1'b1;
                        res.out_byte   = b;
                    end
                    default: begin
                        scan_st       = SC_FIELD;
                        res.field_end = 1'b1;
                    end
                endcase
            end else if (b == CH_SPACE) begin
                res.byte_valid = 1'b1;
                res.out_byte   = b;
            end else begin
                case (scan_st)
                    SC_AFTER: res.status = STS_CHAR_SEP;
                    SC_QSEEN: begin
                        // byte after the closing quote is dropped
                        scan_st       = SC_AFTER;
                        res.field_end = 1'b1;
                    end
                    default: begin
                        res.byte_valid = 1'b1;
                        res.out_byte   = b;
                    end
                endcase
            end
        end
        if (emit && (res.line_end || res.status != STS_OK)) begin
            scan_st    = SC_FIELD;
            line_chars = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : scan_monitor
        t_csv_result got;
        t_csv_result want;
        t_csv_result res;
        logic        emit;
        if (!i_rst_n) begin
            sep_byte   = SEP_RESET;
            scan_st    = SC_FIELD;
            line_chars = 1'b0;
            expected_tokens.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                sep_byte = i_cfg_data;
            // output first: a result never belongs to the item taken at the same edge
            if (i_pop && !i_empty) begin
                got = '{i_byte_valid, i_out_byte, i_field_end, i_line_end, i_status};
                if (expected_tokens.size() == 0) begin
                    $error("result with nothing expected: bv=%0d byte=0x%0h fe=%0d le=%0d st=%0d",
                           got.byte_valid, got.out_byte, got.field_end, got.line_end,
                           got.status);
                    errors++;
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("byte_valid", want.byte_valid, got.byte_valid);
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("field_end", want.field_end, got.field_end);
                    check_field("line_end", want.line_end, got.line_end);
                    check_field("status", want.status, got.status);
                end
            end
            if (i_push && !i_full) begin
                tokenize_item(i_kind, i_in_byte, emit, res);
                if (emit)
                    expected_tokens.insert(expected_tokens.size(), res);
            end
        end
        o_pending <= expected_tokens.size();
        o_errors  <= errors;
    end

endmodule
`default_nettype wire

>>> tb/tb_csv_field_tokenizer.sv
// Top of the CSV field tokenizer testbench: clock, reset, stimulus and verdict.
// Depends on csvt_pkg, csv_field_tokenizer and csvt_token_checker.
`default_nettype none
module tb_csv_field_tokenizer;
    import csvt_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = 8'h00;
    logic       push      = 1'b0;
    logic       kind      = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       pop       = 1'b0;

    logic       cfg_ready;
    logic       full;
    logic       empty;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       field_end;
    logic       line_end;
    logic [2:0] status;

    int         errors;
    int         pending;
    int         stall_cycles  = 0;
    int         items_sent    = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    logic [7:0] cur_sep       = SEP_RESET;

    logic [7:0] sep_plan [0:8] = '{CH_COMMA, 8'h00, CH_SPACE, 8'hFF, CH_QUOTE, 8'h3B,
                                   CH_CR, CH_LF, 8'h09};

    csv_field_tokenizer dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .push         (push),
        .full         (full),
        .i_kind       (kind),
        .i_in_byte    (in_byte),
        .empty        (empty),
        .pop          (pop),
        .o_byte_valid (byte_valid),
        .o_out_byte   (out_byte),
        .o_field_end  (field_end),
        .o_line_end   (line_end),
        .o_status     (status)
    );

    csvt_token_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_push       (push),
        .i_full       (full),
        .i_kind       (kind),
        .i_in_byte    (in_byte),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_byte_valid (byte_valid),
        .i_out_byte   (out_byte),
        .i_field_end  (field_end),
        .i_line_end   (line_end),
        .i_status     (status),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    always #10 clk = ~clk;

    always @(negedge clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_csv_field_tokenizer: done, errors");
            $finish;
        end
    end

    // Entered and left at a falling edge; push stays high into the next call.
    task automatic send_item(input logic k, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        kind    <= k;
        in_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b0, s[i]);
    endtask

    // Let every expected result drain, then allow for items still in flight.
    task automatic wait_idle();
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_sep(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        cur_sep    = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] biased_byte();
        case ($urandom_range(7))
            0:       return CH_QUOTE;
            1:       return CH_CR;
            2:       return CH_LF;
            3:       return CH_SPACE;
            4:       return cur_sep;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One record of plain and quoted fields with random content.
    task automatic send_record();
        int         nfields;
        int         nbytes;
        logic [7:0] b;
        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++) begin
            if (f != 0)
                send_item(1'b0, cur_sep);
            nbytes = $urandom_range(0, 5);
            if ($urandom_range(1)) begin
                send_item(1'b0, CH_QUOTE);
                for (int i = 0; i < nbytes; i++) begin
                    b = biased_byte();
                    send_item(1'b0, b);
                    if (b == CH_QUOTE)
                        send_item(1'b0, CH_QUOTE);
                end
                send_item(1'b0, CH_QUOTE);
            end else begin
                for (int i = 0; i < nbytes; i++) begin
                    do
                        b = 8'($urandom_range(255));
                    while (b == CH_QUOTE || b == CH_CR || b == CH_LF || b == cur_sep);
                    send_item(1'b0, b);
                end
            end
        end
        case ($urandom_range(9))
            0:       send_item(1'b1, 8'($urandom_range(255)));
            1, 2, 3: begin
                send_item(1'b0, CH_CR);
                send_item(1'b0, CH_LF);
            end
            default: send_item(1'b0, CH_LF);
        endcase
    endtask

    initial begin
        int target;
        int n;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 15;
        recv_idle_pct = 58;

        // directed part, reset separator
        send_item(1'b1, 8'h00);             // end of input on an empty line
        send_text("\015\n");                // CR ignored, bare line end
        send_text("\"a\"\"b\"  \"");        // doubled quote, spaces after close, stray quote
        send_text("\"q\"x");                // byte after closing quote is dropped
        send_item(1'b0, 8'h00);             // byte where a separator belongs
        send_text("\"\n");
        send_item(1'b1, 8'hFF);             // unterminated quote at end
        wait_idle();
        write_sep(CH_SPACE);
        send_text("\"p\" ");                // space separator after closing quote
        send_item(1'b0, 8'hFF);
        send_text(" ");
        send_item(1'b1, 8'hA5);

        for (int blk = 0; blk < 9; blk++) begin
            if (blk == 3) begin
                send_idle_pct = 58;
                recv_idle_pct = 15;
            end
            if (blk == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            write_sep((blk == 8) ? 8'($urandom_range(255)) : sep_plan[blk]);
            target = items_sent + 100;
            while (items_sent < target) begin
                if ($urandom_range(4) != 0)
                    send_record();
                else begin
                    // noise: specials and stray end markers
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++) begin
                        if ($urandom_range(7) == 0)
                            send_item(1'b1, 8'($urandom_range(255)));
                        else
                            send_item(1'b0, biased_byte());
                    end
                end
            end
        end

        wait_idle();
        if (errors == 0)
            $display("tb_csv_field_tokenizer: done, clean");
        else
            $display("tb_csv_field_tokenizer: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
